@@ rtl/core/tpl_pkg.sv @@
// Shared constants and types for the tabu pair list.
// Used by the top level and the testbench; no dependencies.
package tpl_pkg;

  // Fixed field widths
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned CUT_W      = 15;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Default sizes
  localparam int unsigned TABLE_SIZE_DEF = 64;
  localparam int unsigned RING_DEPTH_DEF = 16;

  // Register reset values
  localparam logic signed [COEF_W-1:0] COEF_RST   = 16'sd0;
  localparam logic        [CUT_W-1:0]  CUTOFF_RST = 15'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COEF   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 1'd1;

  // Operation codes of the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_MARK  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

endpackage

@@ rtl/core/tabu_pair_list_top.sv @@
// Top level of the tabu pair list: control sequencer, configuration registers
// and output register. Uses tpl_pkg, tpl_ring_mem and tpl_bit_table.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries mode_i, row_index_i and
//   col_index_i; one item is taken per transfer. Output channel
//   (out_valid_o / out_stall_i) returns exactly one result per item with
//   is_forbidden_o (query answer) and recorded_o (mark entered the pair).
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 coefficient, 1 cutoff) at once; write only while the block is idle.
//   Sequence: a query reads the bit table, a mark evicts the oldest pair and
//   then sets the new one (evict, then set); each result is loaded into the
//   output register, and the next item is taken only after that. Clear
//   walks the ring, one entry a cycle, then gives its result from ST_DONE.
//   Reset: the ring empties at once; then a clearing pass writes all
//   2**(2*clog2(TABLE_SIZE)) table bits (4096 by default) to zero, during
//   which in_stall_o is high. Configuration writes are taken throughout.
//   A stalled result holds in the output register; the next item is taken,
//   but its result waits until the register frees.
module tabu_pair_list_top #(
  parameter int unsigned TABLE_SIZE = tpl_pkg::TABLE_SIZE_DEF,
  parameter int unsigned RING_DEPTH = tpl_pkg::RING_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tpl_pkg::MODE_W-1:0]       mode_i,
  input  logic signed [tpl_pkg::IDX_W-1:0] row_index_i,
  input  logic signed [tpl_pkg::IDX_W-1:0] col_index_i,
  // Output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             is_forbidden_o,
  output logic                             recorded_o,
  // Configuration
  input  logic                             cfg_we_i,
  input  logic [tpl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tpl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned IW  = $clog2(TABLE_SIZE);
  localparam int unsigned TAW = 2 * IW;
  localparam int unsigned RW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [RW-1:0] SLOT_LAST = RW'(RING_DEPTH - 1);
  localparam int unsigned XW  = tpl_pkg::COEF_W + 1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MARK,
    ST_QUERY,
    ST_CLEAR,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic signed [tpl_pkg::COEF_W-1:0] coef_q;
  logic        [tpl_pkg::CUT_W-1:0]  cutoff_q;

  // Control counters and flags
  logic [RW-1:0]   slot_q, slot_d;
  logic [RW-1:0]   walk_q, walk_d;
  logic [TAW-1:0]  init_cnt_q;
  logic            ring_vld_q [RING_DEPTH];
  logic            out_vld_q, out_forb_q, out_rec_q;

  // Latched item
  logic            mark_en_q, qry_en_q;
  logic [TAW-1:0]  new_pair_q;

  // Memory ports
  logic            ring_we;
  logic [RW-1:0]   ring_raddr;
  logic [TAW-1:0]  ring_rdata;
  logic            tbl_we, tbl_wdata, tbl_re, tbl_rdata;
  logic [TAW-1:0]  tbl_waddr;

  // Decode
  logic signed [XW-1:0] coef_x, cut_x, ncut_x;
  logic                 row_ok, col_ok, mark_ok, qry_ok, accept, out_free;
  logic [IW-1:0]        row_idx, col_idx;
  logic [TAW-1:0]       in_pair;

  always_comb begin
    coef_x  = {coef_q[tpl_pkg::COEF_W-1], coef_q};
    cut_x   = {{(XW - tpl_pkg::CUT_W){1'b0}}, cutoff_q};
    ncut_x  = -cut_x;
    row_ok  = !row_index_i[tpl_pkg::IDX_W-1]
              && (32'(row_index_i[tpl_pkg::IDX_W-2:0]) < TABLE_SIZE);
    col_ok  = !col_index_i[tpl_pkg::IDX_W-1]
              && (32'(col_index_i[tpl_pkg::IDX_W-2:0]) < TABLE_SIZE);
    row_idx = IW'(row_index_i[tpl_pkg::IDX_W-2:0]);
    col_idx = IW'(col_index_i[tpl_pkg::IDX_W-2:0]);
    in_pair = {row_idx, col_idx};
    mark_ok = (coef_x >= cut_x) && row_ok && col_ok;
    qry_ok  = !((coef_x < cut_x) && (coef_x > ncut_x)) && row_ok && col_ok;
    accept  = (state_q == ST_IDLE) && in_valid_i;
    out_free = !out_vld_q || !out_stall_i;
  end

  // Next state and memory controls
  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    walk_d    = walk_q;
    ring_we   = 1'b0;
    tbl_we    = 1'b0;
    tbl_waddr = in_pair;
    tbl_wdata = 1'b0;
    tbl_re    = 1'b0;
    case (state_q)
      ST_INIT: begin
        tbl_we    = 1'b1;
        tbl_waddr = init_cnt_q;
        if (init_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (tpl_pkg::mode_e'(mode_i))
            tpl_pkg::MODE_MARK: begin
              // evict the oldest pair first
              tbl_we    = mark_ok && ring_vld_q[slot_q];
              tbl_waddr = ring_rdata;
              state_d   = ST_MARK;
            end
            tpl_pkg::MODE_QUERY: begin
              tbl_re  = 1'b1;
              state_d = ST_QUERY;
            end
            tpl_pkg::MODE_CLEAR: begin
              walk_d  = '0;
              state_d = ST_CLEAR;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_MARK: begin
        if (out_free) begin
          state_d = ST_IDLE;
          if (mark_en_q) begin
            tbl_we    = 1'b1;
            tbl_waddr = new_pair_q;
            tbl_wdata = 1'b1;
            ring_we   = 1'b1;
            slot_d    = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
          end
        end
      end
      ST_QUERY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        // drop the bit of each live ring entry
        tbl_we    = ring_vld_q[walk_q];
        tbl_waddr = ring_rdata;
        if (walk_q == SLOT_LAST) begin
          slot_d  = '0;
          state_d = ST_DONE;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    ring_raddr = (state_d == ST_CLEAR) ? walk_d : slot_d;
  end

  // State, counters, valid bits and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      slot_q     <= '0;
      walk_q     <= '0;
      init_cnt_q <= '0;
      out_vld_q  <= 1'b0;
      out_forb_q <= 1'b0;
      out_rec_q  <= 1'b0;
      for (int k = 0; k < RING_DEPTH; k++) begin
        ring_vld_q[k] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      walk_q  <= walk_d;
      if (state_q == ST_INIT) begin
        init_cnt_q <= init_cnt_q + 1'b1;
      end
      if (ring_we) begin
        ring_vld_q[slot_q] <= 1'b1;
      end
      if ((state_q == ST_CLEAR) && (walk_q == SLOT_LAST)) begin
        for (int k = 0; k < RING_DEPTH; k++) begin
          ring_vld_q[k] <= 1'b0;
        end
      end
      // Load a new result, or retire the old one on transfer
      if (out_free) begin
        case (state_q)
          ST_MARK: begin
            out_vld_q  <= 1'b1;
            out_forb_q <= 1'b0;
            out_rec_q  <= mark_en_q;
          end
          ST_QUERY: begin
            out_vld_q  <= 1'b1;
            out_forb_q <= qry_en_q && tbl_rdata;
            out_rec_q  <= 1'b0;
          end
          ST_DONE: begin
            out_vld_q  <= 1'b1;
            out_forb_q <= 1'b0;
            out_rec_q  <= 1'b0;
          end
          default: out_vld_q <= 1'b0;
        endcase
      end
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mark_en_q  <= mark_ok;
      qry_en_q   <= qry_ok;
      new_pair_q <= in_pair;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= tpl_pkg::COEF_RST;
      cutoff_q <= tpl_pkg::CUTOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tpl_pkg::CFG_COEF:   coef_q   <= cfg_data_i[tpl_pkg::COEF_W-1:0];
        tpl_pkg::CFG_CUTOFF: cutoff_q <= cfg_data_i[tpl_pkg::CUT_W-1:0];
        default: ;
      endcase
    end
  end

  tpl_ring_mem #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (RW),
    .DATA_W (TAW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (slot_q),
    .wdata_i (new_pair_q),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  tpl_bit_table #(
    .ADDR_W (TAW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (in_pair),
    .rdata_o (tbl_rdata)
  );

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_vld_q;
  assign is_forbidden_o = out_forb_q;
  assign recorded_o     = out_rec_q;

endmodule

@@ rtl/core/tpl_ring_mem.sv @@
// Ring of recently marked pairs: one write port, one read port, read data registered.
// A read of the entry being written in the same cycle returns the new data.
// Depends on nothing.
module tpl_ring_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write the entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read every cycle, forward a write to the same entry
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tpl_bit_table.sv @@
// Square table of forbidden-pair bits, addressed by {row, col}.
// One write port, one read port with registered data held between reads.
// Depends on nothing.
module tpl_bit_table #(
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic              wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic              rdata_o
);

  logic mem [2**ADDR_W];
  logic rdata_q;

  // Write one bit
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read on request, hold otherwise
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tpl_checker.sv @@
// Port-level checks for the tabu pair list, bound to the top level.
// Depends on tabu_pair_list_top.
module tpl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic is_forbidden_o,
  input logic recorded_o
);

  // One item at a time: a transfer makes the block busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a previous item is in work");

  // A new result only comes out of work in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in work");

  // Query and mark answers never show together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_forbidden_o && recorded_o))
    else $error("both result flags set");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(is_forbidden_o) && $stable(recorded_o)))
    else $error("stalled result changed");

endmodule

bind tabu_pair_list_top tpl_checker u_tpl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .is_forbidden_o (is_forbidden_o),
  .recorded_o     (recorded_o)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for tabu_pair_list_top: directed and random mark, query
// and clear traffic under several register settings, checked against a tabu model.
// Depends on tpl_pkg and the tabu_pair_list_top RTL.
module tb_top;

  localparam int unsigned MODE_W     = tpl_pkg::MODE_W;
  localparam int unsigned IDX_W      = tpl_pkg::IDX_W;
  localparam int unsigned COEF_W     = tpl_pkg::COEF_W;
  localparam int unsigned CUT_W      = tpl_pkg::CUT_W;
  localparam int unsigned CFG_IDX_W  = tpl_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = tpl_pkg::CFG_DATA_W;

  localparam int TBL_N = tpl_pkg::TABLE_SIZE_DEF;
  localparam int RING_N = tpl_pkg::RING_DEPTH_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 120;
  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic signed [IDX_W-1:0] row;
    logic signed [IDX_W-1:0] col;
  } tabu_op_t;

  typedef struct {
    tabu_op_t op;
    logic     forbidden;
    logic     recorded;
  } tabu_answer_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [MODE_W-1:0]       mode_r = '0;
  logic signed [IDX_W-1:0] row_r = '0;
  logic signed [IDX_W-1:0] col_r = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    is_forbidden;
  logic                    recorded;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // Stimulus and checking state
  tabu_op_t     op_q[$];
  tabu_answer_t answer_q[$];
  logic         in_taken = 1'b0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           hold_req = 0;
  int           hold_ack = 0;
  int           hold_left = 0;
  int           cycle_cnt = 0;
  int           mismatch_cnt = 0;

  // Tabu list model
  logic signed [IDX_W-1:0]  ring_row [RING_N];
  logic signed [IDX_W-1:0]  ring_col [RING_N];
  bit                       pair_tbl [TBL_N*TBL_N];
  int unsigned              slot_m;
  logic signed [COEF_W-1:0] coef_m = tpl_pkg::COEF_RST;
  logic [CUT_W-1:0]         cut_m = tpl_pkg::CUTOFF_RST;

  tabu_pair_list_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode_r),
    .row_index_i    (row_r),
    .col_index_i    (col_r),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .is_forbidden_o (is_forbidden),
    .recorded_o     (recorded),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  function automatic bit idx_valid(logic signed [IDX_W-1:0] v);
    int iv;
    iv = v;
    return iv >= 0 && iv < TBL_N;
  endfunction

  // Empty the ring and the pair table, rewind the write slot
  function automatic void clear_tabu();
    for (int k = 0; k < RING_N; k++) begin
      ring_row[k] = '1;
      ring_col[k] = '1;
    end
    foreach (pair_tbl[k]) pair_tbl[k] = 1'b0;
    slot_m = 0;
  endfunction

  // Apply one operation to the model and return its answer
  function automatic tabu_answer_t apply_tabu_op(tabu_op_t op);
    tabu_answer_t a;
    int cv, lv, r, c, orow, ocol;
    a.op = op;
    a.forbidden = 1'b0;
    a.recorded = 1'b0;
    cv = coef_m;
    lv = cut_m;
    r = op.row;
    c = op.col;
    case (op.mode)
      tpl_pkg::MODE_MARK: begin
        if (cv >= lv && idx_valid(op.row) && idx_valid(op.col)) begin
          // evict the oldest pair before storing the new one
          if (idx_valid(ring_row[slot_m]) && idx_valid(ring_col[slot_m])) begin
            orow = ring_row[slot_m];
            ocol = ring_col[slot_m];
            pair_tbl[orow*TBL_N + ocol] = 1'b0;
          end
          ring_row[slot_m] = op.row;
          ring_col[slot_m] = op.col;
          pair_tbl[r*TBL_N + c] = 1'b1;
          slot_m = (slot_m + 1) % RING_N;
          a.recorded = 1'b1;
        end
      end
      tpl_pkg::MODE_QUERY: begin
        if (!(cv < lv && cv > -lv) && idx_valid(op.row) && idx_valid(op.col))
          a.forbidden = pair_tbl[r*TBL_N + c];
      end
      tpl_pkg::MODE_CLEAR: begin
        clear_tabu();
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  // Mostly small indices so pairs repeat and evictions hit; some raw bit patterns
  function automatic logic signed [IDX_W-1:0] random_index();
    int p;
    p = $urandom_range(99);
    if (p < 60) return IDX_W'($urandom_range(5));
    else if (p < 85) return IDX_W'($urandom_range(TBL_N-1));
    else return IDX_W'($urandom_range((1 << IDX_W) - 1));
  endfunction

  function automatic tabu_op_t random_op();
    tabu_op_t op;
    int pick;
    pick = $urandom_range(99);
    if (pick < 46) op.mode = tpl_pkg::MODE_MARK;
    else if (pick < 90) op.mode = tpl_pkg::MODE_QUERY;
    else if (pick < 92) op.mode = tpl_pkg::MODE_CLEAR;
    else if (pick < 95) op.mode = MODE_UNUSED;
    else op.mode = MODE_W'($urandom_range((1 << MODE_W) - 1));
    op.row = random_index();
    op.col = random_index();
    return op;
  endfunction

  task automatic push_op(logic [MODE_W-1:0] mode, int row, int col);
    tabu_op_t op;
    op.mode = mode;
    op.row = IDX_W'(row);
    op.col = IDX_W'(col);
    op_q.push_back(op);
  endtask

  task automatic push_random(int n);
    repeat (n) op_q.push_back(random_op());
  endtask

  // Hold until every queued item is sent and every answer has come back
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (op_q.size() != 0 || answer_q.size() != 0 || in_valid);
    @(negedge clk_i);
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == tpl_pkg::CFG_COEF) coef_m = data;
    else cut_m = data[CUT_W-1:0];
  endtask

  task automatic start_phase(logic [CFG_DATA_W-1:0] coef, logic [CFG_DATA_W-1:0] cut,
                             int send_pct, int recv_pct);
    wait_quiet();
    set_register(tpl_pkg::CFG_COEF, coef);
    set_register(tpl_pkg::CFG_CUTOFF, cut);
    @(posedge clk_i);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // Present the next item once the current one has transferred
  always @(negedge clk_i) begin
    if (!in_valid || in_taken) begin
      if (op_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        mode_r <= op_q[0].mode;
        row_r <= op_q[0].row;
        col_r <= op_q[0].col;
        void'(op_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Drive the result stall: random, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= (hold_req != hold_ack) || (hold_left > 1) ||
                 ($urandom_range(99) < stall_pct);
  end

  // Count cycles, check each result transfer, predict each input transfer
  always @(posedge clk_i) begin : monitor
    tabu_answer_t want;
    tabu_op_t     seen;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (rst_ni && out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $display("%0t: result with none expected: forbidden %0b recorded %0b",
                   $time, is_forbidden, recorded);
          mismatch_cnt++;
        end else begin
          want = answer_q.pop_front();
          if (want.forbidden !== is_forbidden || want.recorded !== recorded) begin
            $display("%0t: mode %0d row %0d col %0d: expected forbidden %0b recorded %0b,",
                     $time, want.op.mode, want.op.row, want.op.col,
                     want.forbidden, want.recorded);
            $display("%0t:   actual forbidden %0b recorded %0b",
                     $time, is_forbidden, recorded);
            mismatch_cnt++;
          end
        end
      end
      if (rst_ni && in_valid && !in_stall) begin
        seen.mode = mode_r;
        seen.row = row_r;
        seen.col = col_r;
        answer_q.push_back(apply_tabu_op(seen));
      end
    end
  end

  initial begin
    clear_tabu();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Coefficient 1.0, cutoff 0.5: marks and queries active, no idling
    start_phase(16'h0100, 16'h0080, 0, 0);
    push_op(tpl_pkg::MODE_MARK, 0, 0);
    push_op(tpl_pkg::MODE_MARK, 63, 63);
    push_op(tpl_pkg::MODE_MARK, 0, 63);
    push_op(tpl_pkg::MODE_MARK, 63, 0);
    push_op(tpl_pkg::MODE_QUERY, 0, 0);
    push_op(tpl_pkg::MODE_QUERY, 63, 63);
    push_op(tpl_pkg::MODE_QUERY, 0, 63);
    push_op(tpl_pkg::MODE_QUERY, 63, 0);
    push_op(tpl_pkg::MODE_QUERY, 1, 1);
    push_op(tpl_pkg::MODE_MARK, -1, 5);
    push_op(tpl_pkg::MODE_MARK, 5, -1);
    push_op(tpl_pkg::MODE_MARK, -64, 63);
    push_op(tpl_pkg::MODE_MARK, 63, -2);
    push_op(tpl_pkg::MODE_QUERY, -1, 0);
    push_op(tpl_pkg::MODE_QUERY, 0, -64);
    push_op(MODE_UNUSED, 0, 0);
    push_op(tpl_pkg::MODE_CLEAR, 0, 0);
    push_op(tpl_pkg::MODE_QUERY, 0, 0);
    push_op(tpl_pkg::MODE_QUERY, 63, 63);
    wait_quiet();
    push_random(150);
    @(posedge clk_i);
    hold_req++;

    // Coefficient below cutoff and inside the dead band: marks skipped, queries zero
    start_phase(16'h0064, 16'h0080, 68, 0);
    push_op(tpl_pkg::MODE_MARK, 2, 2);
    push_op(tpl_pkg::MODE_QUERY, 2, 2);
    push_random(100);

    // Negative coefficient: marks skipped, queries answer the table
    start_phase(16'hFF38, 16'h0080, 0, 68);
    push_random(100);

    // Both registers at their maximum, long receiver hold-off
    start_phase(16'h7FFF, 16'h7FFF, 20, 20);
    push_random(200);
    @(posedge clk_i);
    hold_req++;

    // Zero coefficient and zero cutoff
    start_phase(16'h0000, 16'h0000, 0, 0);
    push_random(150);

    // Most negative coefficient against the largest cutoff
    start_phase(16'h8000, 16'h7FFF, 20, 20);
    push_random(100);

    // Most negative coefficient with zero cutoff, then back to normal marking
    start_phase(16'h8000, 16'h0000, 0, 0);
    push_random(25);
    start_phase(16'h0200, 16'h0001, 0, 0);
    push_random(60);
    wait_quiet();
    push_random(65);

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && answer_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tpl_pkg.sv
rtl/core/tpl_ring_mem.sv
rtl/core/tpl_bit_table.sv
rtl/core/tabu_pair_list_top.sv
rtl/core/tpl_checker.sv
tb/tb_top.sv
